/* sv/zero_crossing_segmenter_macros.svh */
// Assertion macros used by the zero-crossing segmenter controller.
`ifndef ZERO_CROSSING_SEGMENTER_MACROS_SVH
`define ZERO_CROSSING_SEGMENTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/zcs_pkg.sv */
// Shared types and constants for the zero-crossing segmenter.
`default_nettype none

package zcs_pkg;

    localparam int ZCS_SAMPLE_BITS = 16;
    localparam int ZCS_INDEX_BITS  = 16;
    localparam int ZCS_WINDOW_LEN  = 65536;
    localparam int ZCS_SUM_BITS    = 32;
    localparam int ZCS_LEN_BITS    = 17;
    localparam int ZCS_GATE_BITS   = 9;
    localparam int ZCS_CFG_IDX_BITS  = 2;
    localparam int ZCS_CFG_DATA_BITS = 15;

    typedef enum logic [ZCS_CFG_IDX_BITS-1:0] {
        CFG_AMP_THRESHOLD,
        CFG_SILENCE_LEVEL,
        CFG_SILENCE_RUN_LIMIT,
        CFG_GATE_LOW_LEVEL
    } zcs_cfg_reg_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic div_start;
        logic commit;
        logic skip;
    } zcs_cmd_t;

    typedef struct packed {
        logic crossing;
        logic div_done;
        logic out_free;
    } zcs_status_t;

endpackage

`default_nettype wire

/* sv/zcs_div.sv */
// Bit-serial restoring divider that forms the segment mean, one quotient bit per cycle.
`default_nettype none

module zcs_div import zcs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [ZCS_SUM_BITS-1:0] dividend,
    input  logic [ZCS_LEN_BITS-1:0] divisor,
    output logic                    done,
    output logic [ZCS_SUM_BITS-1:0] quotient
);

    localparam int CntBits = $clog2(ZCS_SUM_BITS);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CntBits-1:0]      cnt_reg;
    logic [ZCS_LEN_BITS-1:0] rem_reg;
    logic [ZCS_LEN_BITS-1:0] rem_next;
    logic [ZCS_SUM_BITS-1:0] quo_reg;
    logic [ZCS_SUM_BITS-1:0] quo_next;
    logic [ZCS_LEN_BITS:0]   shifted;
    logic [ZCS_LEN_BITS:0]   divisor_ext;
    logic                    fits;

    always_comb begin
        shifted     = {rem_reg, quo_reg[ZCS_SUM_BITS-1]};
        divisor_ext = {1'b0, divisor};
        fits        = (shifted >= divisor_ext);
        if (fits) begin
            rem_next = ZCS_LEN_BITS'(shifted - divisor_ext);
        end else begin
            rem_next = shifted[ZCS_LEN_BITS-1:0];
        end
        quo_next = {quo_reg[ZCS_SUM_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CntBits'(1);
            if (cnt_reg == CntBits'(ZCS_SUM_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/zcs_datapath.sv */
// Datapath of the segmenter: configuration, segment state, crossing test and result register.
`default_nettype none

module zcs_datapath import zcs_pkg::*; (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  zcs_cmd_t                            cmd,
    output zcs_status_t                         status,
    input  logic                                cfg_valid,
    input  logic [ZCS_CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [ZCS_CFG_DATA_BITS-1:0]        cfg_data,
    input  logic signed [ZCS_SAMPLE_BITS-1:0]   s_sample,
    input  logic [ZCS_INDEX_BITS-1:0]           s_sample_index,
    input  logic                                s_window_start,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [ZCS_INDEX_BITS-1:0]           m_crossing_position,
    output logic signed [ZCS_SAMPLE_BITS:0]     m_crossing_slope,
    output logic signed [ZCS_SAMPLE_BITS-1:0]   m_crossing_sample,
    output logic signed [ZCS_SAMPLE_BITS-1:0]   m_before_sample,
    output logic                                m_closed_valid,
    output logic [15:0]                         m_closed_peak,
    output logic [15:0]                         m_closed_mean,
    output logic [ZCS_GATE_BITS-1:0]            m_closed_gate,
    output logic [15:0]                         m_crossing_number,
    output logic [15:0]                         m_overall_peak
);

    localparam logic [ZCS_GATE_BITS-1:0] GATE_FULL = 9'd256;
    localparam logic [15:0]              MEAN_MAX  = 16'h8000;
    localparam logic [2:0]               RUN_MAX   = 3'd7;

    // Configuration registers.
    logic [7:0]  amp_thr_reg;
    logic [14:0] sil_level_reg;
    logic [2:0]  run_limit_reg;
    logic [8:0]  gate_low_reg;

    // Captured request.
    logic signed [ZCS_SAMPLE_BITS-1:0] in_sample_reg;
    logic [ZCS_INDEX_BITS-1:0]         in_index_reg;
    logic                              in_start_reg;

    // Segment state.
    logic signed [ZCS_SAMPLE_BITS-1:0] prev_sample_reg;
    logic [15:0]                       seg_peak_reg;
    logic [ZCS_SUM_BITS-1:0]           seg_sum_reg;
    logic [ZCS_LEN_BITS-1:0]           seg_len_reg;
    logic [15:0]                       last_mean_reg;
    logic [ZCS_LEN_BITS-1:0]           acc_count_reg;
    logic [2:0]                        silent_run_reg;
    logic [15:0]                       peak_all_reg;
    logic                              m_valid_reg;

    logic [15:0]                       mag;
    logic [15:0]                       base_peak;
    logic [ZCS_SUM_BITS-1:0]           base_sum;
    logic [ZCS_LEN_BITS-1:0]           base_len;
    logic [15:0]                       peak_acc;
    logic [ZCS_SUM_BITS:0]             sum_wide;
    logic [ZCS_SUM_BITS-1:0]           sum_acc;
    logic [ZCS_LEN_BITS-1:0]           len_acc;
    logic [23:0]                       thr_prod;
    logic [23:0]                       peak_scaled;
    logic                              crossing;
    logic                              div_done;
    logic [ZCS_SUM_BITS-1:0]           quotient;
    logic [15:0]                       mean;
    logic                              closed_valid;
    logic [ZCS_GATE_BITS-1:0]          gate_low;
    logic [ZCS_GATE_BITS-1:0]          gate;
    logic [2:0]                        silent_run_next;
    logic [15:0]                       peak_all_next;
    logic signed [ZCS_SAMPLE_BITS:0]   slope;
    logic [15:0]                       count_out;
    logic [ZCS_INDEX_BITS:0]           index_ext;
    logic [ZCS_INDEX_BITS-1:0]         position;

    zcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (seg_sum_reg),
        .divisor  (seg_len_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        if (in_sample_reg[ZCS_SAMPLE_BITS-1]) begin
            mag = ~unsigned'(in_sample_reg) + 16'd1;
        end else begin
            mag = unsigned'(in_sample_reg);
        end
        base_peak = in_start_reg ? '0 : seg_peak_reg;
        base_sum  = in_start_reg ? '0 : seg_sum_reg;
        base_len  = in_start_reg ? '0 : seg_len_reg;
        peak_acc  = (mag > base_peak) ? mag : base_peak;
        sum_wide  = {1'b0, base_sum} + {17'd0, mag};
        sum_acc   = sum_wide[ZCS_SUM_BITS] ? '1 : sum_wide[ZCS_SUM_BITS-1:0];
        len_acc   = (base_len == '1) ? base_len : base_len + ZCS_LEN_BITS'(1);
    end

    always_comb begin
        thr_prod    = 24'(last_mean_reg) * 24'(amp_thr_reg);
        peak_scaled = {seg_peak_reg, 8'd0};
        crossing    = prev_sample_reg[ZCS_SAMPLE_BITS-1] && !in_sample_reg[ZCS_SAMPLE_BITS-1]
                      && (peak_scaled > thr_prod);
    end

    always_comb begin
        mean            = (quotient > 32'(MEAN_MAX)) ? MEAN_MAX : quotient[15:0];
        closed_valid    = (acc_count_reg != '0);
        gate_low        = (gate_low_reg > GATE_FULL) ? GATE_FULL : gate_low_reg;
        gate            = '0;
        silent_run_next = silent_run_reg;
        if (closed_valid) begin
            if (mean < {1'b0, sil_level_reg}) begin
                if (silent_run_reg > run_limit_reg) begin
                    gate = gate_low;
                end else begin
                    if (silent_run_reg != RUN_MAX) begin
                        silent_run_next = silent_run_reg + 3'd1;
                    end
                    gate = GATE_FULL;
                end
            end else begin
                gate            = GATE_FULL;
                silent_run_next = '0;
            end
        end
        peak_all_next = (seg_peak_reg > peak_all_reg) ? seg_peak_reg : peak_all_reg;
        slope         = {in_sample_reg[ZCS_SAMPLE_BITS-1], in_sample_reg}
                        - {prev_sample_reg[ZCS_SAMPLE_BITS-1], prev_sample_reg};
        count_out     = acc_count_reg[ZCS_LEN_BITS-1] ? 16'hFFFF : acc_count_reg[15:0];
        index_ext     = {1'b0, in_index_reg};
        if (32'(index_ext) >= ZCS_WINDOW_LEN) begin
            position = ZCS_INDEX_BITS'(ZCS_WINDOW_LEN - 1);
        end else begin
            position = in_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_thr_reg   <= 8'd51;
            sil_level_reg <= 15'd33;
            run_limit_reg <= 3'd2;
            gate_low_reg  <= 9'd51;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_AMP_THRESHOLD:     amp_thr_reg   <= cfg_data[7:0];
                CFG_SILENCE_LEVEL:     sil_level_reg <= cfg_data[14:0];
                CFG_SILENCE_RUN_LIMIT: run_limit_reg <= cfg_data[2:0];
                CFG_GATE_LOW_LEVEL:    gate_low_reg  <= cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_sample_reg <= s_sample;
            in_index_reg  <= s_sample_index;
            in_start_reg  <= s_window_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
            seg_peak_reg    <= '0;
            seg_sum_reg     <= '0;
            seg_len_reg     <= '0;
            last_mean_reg   <= '0;
            acc_count_reg   <= '0;
            silent_run_reg  <= '0;
            peak_all_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.accum) begin
                seg_peak_reg <= peak_acc;
                seg_sum_reg  <= sum_acc;
                seg_len_reg  <= len_acc;
                if (in_start_reg) begin
                    last_mean_reg <= '0;
                    acc_count_reg <= '0;
                end
            end
            if (cmd.skip) begin
                prev_sample_reg <= in_sample_reg;
            end
            if (cmd.commit) begin
                prev_sample_reg <= in_sample_reg;
                last_mean_reg   <= mean;
                seg_peak_reg    <= '0;
                seg_sum_reg     <= '0;
                seg_len_reg     <= '0;
                if (acc_count_reg != '1) begin
                    acc_count_reg <= acc_count_reg + ZCS_LEN_BITS'(1);
                end
                silent_run_reg  <= silent_run_next;
                peak_all_reg    <= peak_all_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_crossing_position <= position;
            m_crossing_slope    <= slope;
            m_crossing_sample   <= in_sample_reg;
            m_before_sample     <= prev_sample_reg;
            m_closed_valid      <= closed_valid;
            m_closed_peak       <= closed_valid ? seg_peak_reg : 16'd0;
            m_closed_mean       <= closed_valid ? mean : 16'd0;
            m_closed_gate       <= gate;
            m_crossing_number   <= count_out;
            m_overall_peak      <= peak_all_next;
        end
    end

    assign status.crossing = crossing;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;

endmodule

`default_nettype wire

/* sv/zcs_ctrl.sv */
// Controller state machine that sequences each request through the datapath.
`default_nettype none

`include "zero_crossing_segmenter_macros.svh"

module zcs_ctrl import zcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  zcs_status_t status,
    output zcs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.crossing) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.skip   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `ZCS_ASSERT_SAME(a_commit_needs_room, cmd.commit, status.out_free, "result committed over a waiting result")
    `ZCS_ASSERT_NEXT(a_load_then_fold, cmd.load, cmd.accum, "captured request was not folded next cycle")
    `ZCS_ASSERT_SAME(a_single_command, 1'b1, $onehot0(cmd), "more than one datapath command at once")
    `ZCS_ASSERT_NEXT(a_div_clears_done, cmd.div_start, !status.div_done && state_reg == ST_DIV, "divider done not cleared on start")

endmodule

`default_nettype wire

/* sv/zero_crossing_segmenter.sv */
// Top level of the zero-crossing segmenter: controller, datapath and ports.
//
//   Channel   Direction  Handshake            Carries
//   s_        in         s_valid / s_ready    sample, sample index, window start
//   m_        out        m_valid / m_ready    one record per accepted rising crossing
//   cfg_      in         cfg_valid/cfg_ready  register index and write data
//
// A sample that is not an accepted crossing passes through the idle, accumulate and check states.
// An accepted crossing then waits in the divide state on the serial divider, which forms
// the segment mean one quotient bit per cycle, and commits once the output register is free.
// Reset is synchronous and clears all segment state at once; no clearing pass.
// A finished record waits in the output register while the next sample is taken;
// a further crossing holds in its last step until that register is free.
`default_nettype none

module zero_crossing_segmenter import zcs_pkg::*; (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ZCS_SAMPLE_BITS-1:0]   s_sample,
    input  logic [ZCS_INDEX_BITS-1:0]           s_sample_index,
    input  logic                                s_window_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ZCS_INDEX_BITS-1:0]           m_crossing_position,
    output logic signed [ZCS_SAMPLE_BITS:0]     m_crossing_slope,
    output logic signed [ZCS_SAMPLE_BITS-1:0]   m_crossing_sample,
    output logic signed [ZCS_SAMPLE_BITS-1:0]   m_before_sample,
    output logic                                m_closed_valid,
    output logic [15:0]                         m_closed_peak,
    output logic [15:0]                         m_closed_mean,
    output logic [ZCS_GATE_BITS-1:0]            m_closed_gate,
    output logic [15:0]                         m_crossing_number,
    output logic [15:0]                         m_overall_peak,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ZCS_CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [ZCS_CFG_DATA_BITS-1:0]        cfg_data
);

    zcs_cmd_t    cmd;
    zcs_status_t status;

    assign cfg_ready = 1'b1;

    zcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    zcs_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_sample            (s_sample),
        .s_sample_index      (s_sample_index),
        .s_window_start      (s_window_start),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_crossing_position (m_crossing_position),
        .m_crossing_slope    (m_crossing_slope),
        .m_crossing_sample   (m_crossing_sample),
        .m_before_sample     (m_before_sample),
        .m_closed_valid      (m_closed_valid),
        .m_closed_peak       (m_closed_peak),
        .m_closed_mean       (m_closed_mean),
        .m_closed_gate       (m_closed_gate),
        .m_crossing_number   (m_crossing_number),
        .m_overall_peak      (m_overall_peak)
    );

endmodule

`default_nettype wire
